[hw/rtl/audio_frame_overwrite_ring_assert.svh]
// Assertion macros shared by the frame ring RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef AUDIO_FRAME_OVERWRITE_RING_ASSERT_SVH
`define AUDIO_FRAME_OVERWRITE_RING_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFOR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame ring check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AFOR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame ring check failed");

`endif

[hw/rtl/afor_pkg.sv]
// Package for the audio frame ring: sizes, operation codes, status struct.
// Used by every module of the block; depends on nothing.
package afor_pkg;

    localparam int DEPTH_FRAMES = 1024;
    localparam int MAX_CHANNELS = 4;

    // Field layout fixed by the item format.
    localparam int SAMPLE_W     = 32;
    localparam int NUM_FIELDS   = 4;
    localparam int OP_W         = 2;
    localparam int CAP_W        = 11;
    localparam int CH_W         = 3;
    localparam int LEVEL_W      = 11;
    localparam int COUNT_W      = 32;
    localparam int S_TDATA_W    = 136;
    localparam int M_TDATA_W    = 272;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam int PTR_W  = (DEPTH_FRAMES > 1) ? $clog2(DEPTH_FRAMES) : 1;
    localparam int FILL_W = $clog2(DEPTH_FRAMES + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
    localparam logic [CH_W-1:0]  CH_RESET  = 3'd2;

    // Register index is taken from paddr bit 2.
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_CHANNELS = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_STATUS = 2'd2,
        OP_RSVD   = 2'd3
    } op_t;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [FILL_W-1:0] fill_t;

    typedef struct packed {
        logic               read_valid;
        logic [LEVEL_W-1:0] fill_level;
        logic [COUNT_W-1:0] written;
        logic [COUNT_W-1:0] rd_total;
        logic [COUNT_W-1:0] dropped;
        logic [COUNT_W-1:0] underrun;
    } stat_t;

    // Advance a slot pointer, wrapping at the effective capacity.
    function automatic ptr_t next_slot(input ptr_t p, input fill_t cap);
        logic [PTR_W:0] n;
        n = {1'b0, p} + (PTR_W + 1)'(1);
        return (32'(n) >= 32'(cap)) ? '0 : n[PTR_W-1:0];
    endfunction

endpackage

[hw/rtl/afor_lane.sv]
// One channel lane of the frame ring: a sample memory with a registered read.
// Depends on afor_pkg.
module afor_lane
    import afor_pkg::*;
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic                rd_en,
    input  ptr_t                wr_addr,
    input  ptr_t                rd_addr,
    input  logic                lane_on,
    input  logic [SAMPLE_W-1:0] wr_sample,
    output logic [SAMPLE_W-1:0] rd_sample
);

    logic [SAMPLE_W-1:0] mem [DEPTH_FRAMES];
    logic [SAMPLE_W-1:0] rd_sample_reg;

    // A lane beyond the active channel count stores zero.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= lane_on ? wr_sample : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_sample_reg <= mem[rd_addr];
        end
    end

    assign rd_sample = rd_sample_reg;

endmodule

[hw/rtl/afor_ctrl.sv]
// Ring control: pointers, fill count, totals and the status stage that
// pairs with the lane read. Depends on afor_pkg and the assertion header.
`include "audio_frame_overwrite_ring_assert.svh"

module afor_ctrl
    import afor_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  op_t   op,
    input  fill_t cap_eff,
    input  logic  cap_clear,
    input  logic  out_free,
    output logic  in_ready,
    output logic  wr_en,
    output logic  rd_en,
    output ptr_t  wr_ptr,
    output ptr_t  rd_ptr,
    output logic  advance,
    output stat_t stat
);

    ptr_t               wr_ptr_reg, wr_ptr_next;
    ptr_t               rd_ptr_reg, rd_ptr_next;
    fill_t              frame_cnt_reg, frame_cnt_next;
    logic [COUNT_W-1:0] written_reg, written_next;
    logic [COUNT_W-1:0] rd_total_reg, rd_total_next;
    logic [COUNT_W-1:0] dropped_reg, dropped_next;
    logic [COUNT_W-1:0] underrun_reg, underrun_next;
    logic               p1_valid_reg, p1_valid_next;
    stat_t              stat_reg, stat_next;
    logic               is_write, is_read, empty, full, got_frame;

    assign is_write = (op == OP_WRITE);
    assign is_read  = (op == OP_READ);
    assign empty    = (frame_cnt_reg == '0);
    assign full     = (32'(frame_cnt_reg) >= 32'(cap_eff));

    assign advance  = p1_valid_reg && out_free;
    assign in_ready = !p1_valid_reg || out_free;
    assign wr_en    = accept && is_write;
    assign rd_en    = accept && is_read && !empty;
    assign wr_ptr   = wr_ptr_reg;
    assign rd_ptr   = rd_ptr_reg;
    assign stat     = stat_reg;

    always_comb
    begin
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        frame_cnt_next = frame_cnt_reg;
        written_next   = written_reg;
        rd_total_next  = rd_total_reg;
        dropped_next   = dropped_reg;
        underrun_next  = underrun_reg;
        got_frame      = 1'b0;
        if (cap_clear)
        begin
            wr_ptr_next    = '0;
            rd_ptr_next    = '0;
            frame_cnt_next = '0;
        end
        else if (accept)
        begin
            if (is_write)
            begin
                wr_ptr_next  = next_slot(wr_ptr_reg, cap_eff);
                written_next = written_reg + 1'b1;
                if (full)
                begin
                    // Overwrite the oldest unread frame.
                    rd_ptr_next    = next_slot(rd_ptr_reg, cap_eff);
                    frame_cnt_next = cap_eff;
                    dropped_next   = dropped_reg + 1'b1;
                end
                else
                begin
                    frame_cnt_next = frame_cnt_reg + 1'b1;
                end
            end
            else if (is_read)
            begin
                if (empty)
                begin
                    underrun_next = underrun_reg + 1'b1;
                end
                else
                begin
                    rd_ptr_next    = next_slot(rd_ptr_reg, cap_eff);
                    frame_cnt_next = frame_cnt_reg - 1'b1;
                    rd_total_next  = rd_total_reg + 1'b1;
                    got_frame      = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        stat_next            = stat_reg;
        p1_valid_next        = p1_valid_reg && !advance;
        if (accept)
        begin
            p1_valid_next         = 1'b1;
            stat_next.read_valid  = got_frame;
            stat_next.fill_level  = LEVEL_W'(frame_cnt_next);
            stat_next.written     = written_next;
            stat_next.rd_total    = rd_total_next;
            stat_next.dropped     = dropped_next;
            stat_next.underrun    = underrun_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            frame_cnt_reg <= '0;
            written_reg   <= '0;
            rd_total_reg  <= '0;
            dropped_reg   <= '0;
            underrun_reg  <= '0;
            p1_valid_reg  <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            frame_cnt_reg <= frame_cnt_next;
            written_reg   <= written_next;
            rd_total_reg  <= rd_total_next;
            dropped_reg   <= dropped_next;
            underrun_reg  <= underrun_next;
            p1_valid_reg  <= p1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg <= stat_next;
    end

    `AFOR_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, 32'(frame_cnt_reg) <= 32'(cap_eff))
    `AFOR_ASSERT_NEXT(a_full_write_keeps_fill, clk, rst_n, accept && is_write && full && !cap_clear, frame_cnt_reg == $past(frame_cnt_reg))
    `AFOR_ASSERT_NEXT(a_status_held, clk, rst_n, p1_valid_reg && !advance, p1_valid_reg)

endmodule

[hw/rtl/afor_merge.sv]
// Merge stage: gathers the lane read data with the status into the
// output register. Depends on afor_pkg and the assertion header.
`include "audio_frame_overwrite_ring_assert.svh"

module afor_merge
    import afor_pkg::*;
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  advance,
    input  stat_t                                 stat,
    input  logic [MAX_CHANNELS-1:0]               lane_on,
    input  logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] rd_sample,
    input  logic                                  out_ready,
    output logic                                  out_free,
    output logic                                  out_valid,
    output stat_t                                 out_stat,
    output logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] out_sample
);

    logic                                  out_valid_reg, out_valid_next;
    stat_t                                 out_stat_reg;
    logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] out_sample_reg, sample_next;

    // Idle lanes and results without a frame read as zero.
    always_comb
    begin
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            sample_next[i] = (stat.read_valid && lane_on[i]) ? rd_sample[i] : '0;
        end
    end

    assign out_free       = !out_valid_reg || out_ready;
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_stat_reg   <= stat;
            out_sample_reg <= sample_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_stat   = out_stat_reg;
    assign out_sample = out_sample_reg;

    `AFOR_ASSERT_NOW(a_no_frame_zero, clk, rst_n, out_valid_reg && !out_stat_reg.read_valid, out_sample_reg == '0)

endmodule

[hw/rtl/audio_frame_overwrite_ring.sv]
// Top level of the overwriting audio frame ring: stream ports, register port,
// channel lanes, control and merge stage. Depends on afor_pkg, afor_lane,
// afor_ctrl and afor_merge.
//
//   Port group   Direction  Carries
//   s_*          in         one operation: write frame, read frame or status
//   m_*          out        one result: frame samples, fill level, totals
//   p*           in/out     APB register port: capacity, channels per frame
//
// An accepted item updates pointers and totals, starts the lane memory
// reads and fills the status stage; the status and lane read data then load
// the output register once it is free. A new item can be accepted every
// cycle while the status stage is empty or the output register is free.
// Reset clears pointers, fill count, totals and valid flags, reloads the
// capacity and channel defaults; memories and data registers keep content.
// A stalled output holds its result; input stops once the status stage fills.
module audio_frame_overwrite_ring
    import afor_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, from bit 0: operation[1:0], in_sample_0, in_sample_1,
    // in_sample_2, in_sample_3, then zero padding.
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, from bit 0: out_sample_0, out_sample_1, out_sample_2,
    // out_sample_3, fill_level, written_count, read_count, dropped_count,
    // underrun_count, then zero padding.
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: read_valid.
    output logic                 m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [CH_W-1:0]  ch_reg, ch_next;
    logic             cfg_wr, cap_clear;
    fill_t            cap_eff;
    logic [CH_W-1:0]  ch_eff;

    logic  accept, in_ready, wr_en, rd_en, advance, out_free;
    op_t   op;
    ptr_t  wr_ptr, rd_ptr;
    stat_t stat, out_stat;

    logic [MAX_CHANNELS-1:0]               lane_on;
    logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] in_sample, rd_sample, out_sample;
    logic [NUM_FIELDS-1:0][SAMPLE_W-1:0]   res_sample;

    // Register port. Writes land in the access phase; pready never stalls.
    // Writing the capacity empties the ring but keeps the totals.
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cap_clear = cfg_wr && (paddr[2] == REG_CAPACITY);

    always_comb
    begin
        cap_next = cap_reg;
        ch_next  = ch_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_CAPACITY: cap_next = pwdata[CAP_W-1:0];
                REG_CHANNELS: ch_next  = pwdata[CH_W-1:0];
                default:      cap_next = cap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            ch_reg  <= CH_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
            ch_reg  <= ch_next;
        end
    end

    assign prdata = (paddr[2] == REG_CHANNELS) ? PDATA_W'(ch_reg) : PDATA_W'(cap_reg);

    // Out-of-range settings are clamped into the range the ring supports.
    always_comb
    begin
        if (32'(cap_reg) < 32'd2)
        begin
            cap_eff = FILL_W'(2);
        end
        else if (32'(cap_reg) > 32'(DEPTH_FRAMES))
        begin
            cap_eff = FILL_W'(DEPTH_FRAMES);
        end
        else
        begin
            cap_eff = FILL_W'(cap_reg);
        end
        if (ch_reg == '0)
        begin
            ch_eff = CH_W'(1);
        end
        else if (32'(ch_reg) > 32'(MAX_CHANNELS))
        begin
            ch_eff = CH_W'(MAX_CHANNELS);
        end
        else
        begin
            ch_eff = ch_reg;
        end
    end

    assign s_tready = in_ready;
    assign accept   = s_tvalid && in_ready;
    assign op       = op_t'(s_tdata[OP_W-1:0]);

    afor_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (op),
        .cap_eff   (cap_eff),
        .cap_clear (cap_clear),
        .out_free  (out_free),
        .in_ready  (in_ready),
        .wr_en     (wr_en),
        .rd_en     (rd_en),
        .wr_ptr    (wr_ptr),
        .rd_ptr    (rd_ptr),
        .advance   (advance),
        .stat      (stat)
    );

    // One lane per channel, all addressed by the same frame slot.
    for (genvar i = 0; i < MAX_CHANNELS; i++)
    begin : g_lane
        assign in_sample[i] = s_tdata[OP_W + SAMPLE_W*i +: SAMPLE_W];
        assign lane_on[i]   = (CH_W'(i) < ch_eff);

        afor_lane u_lane (
            .clk       (clk),
            .wr_en     (wr_en),
            .rd_en     (rd_en),
            .wr_addr   (wr_ptr),
            .rd_addr   (rd_ptr),
            .lane_on   (lane_on[i]),
            .wr_sample (in_sample[i]),
            .rd_sample (rd_sample[i])
        );
    end

    afor_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .stat       (stat),
        .lane_on    (lane_on),
        .rd_sample  (rd_sample),
        .out_ready  (m_tready),
        .out_free   (out_free),
        .out_valid  (m_tvalid),
        .out_stat   (out_stat),
        .out_sample (out_sample)
    );

    // Result fields beyond the built lanes read as zero.
    for (genvar k = 0; k < NUM_FIELDS; k++)
    begin : g_res
        if (k < MAX_CHANNELS)
        begin : g_on
            assign res_sample[k] = out_sample[k];
        end
        else
        begin : g_off
            assign res_sample[k] = '0;
        end
    end

    assign m_tuser = out_stat.read_valid;
    assign m_tdata = {5'b0,
                      out_stat.underrun,
                      out_stat.dropped,
                      out_stat.rd_total,
                      out_stat.written,
                      out_stat.fill_level,
                      res_sample[3],
                      res_sample[2],
                      res_sample[1],
                      res_sample[0]};

endmodule
